// ----- design/qmf_pkg.sv -----
// ----------------------------------------------------------------------------
// qmf_pkg: shared definitions for the shifting queue
// Request and status codes, default sizes and the per-cell control group.
// ----------------------------------------------------------------------------
package qmf_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int SLOT_W         = 7;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_MOVE = 2'd2,
    OP_SWAP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_t;

  // update commands broadcast to every cell; at most one is set
  typedef struct packed {
    logic push_en;
    logic pop_en;
    logic move_en;
    logic swap_en;
  } cell_ctrl_t;

endpackage

// ----- design/qmf_if.sv -----
// ----------------------------------------------------------------------------
// qmf_if: request and response channels of the shifting queue
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qmf_req_if import qmf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  op_t                          operation;
  logic signed [DATA_WIDTH-1:0] push_value;
  logic        [SLOT_W-1:0]     source_slot;
  logic        [SLOT_W-1:0]     target_slot;

  modport source (output valid, operation, push_value, source_slot, target_slot,
                  input ready);
  modport sink   (input valid, operation, push_value, source_slot, target_slot,
                  output ready);
endinterface

interface qmf_rsp_if import qmf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = 8
) ();
  logic                         valid;
  logic                         ready;
  status_t                      status;
  logic        [CNT_W-1:0]      entry_count;
  logic signed [DATA_WIDTH-1:0] head_value;
  logic signed [DATA_WIDTH-1:0] tail_value;

  modport source (output valid, status, entry_count, head_value, tail_value,
                  input ready);
  modport sink   (input valid, status, entry_count, head_value, tail_value,
                  output ready);
endinterface

// ----- design/queue_with_move_forward_unit.sv -----
// ----------------------------------------------------------------------------
// queue_with_move_forward_unit: bounded shifting queue of signed words
// A row of slot cells with push, pop, move-forward and swap-with-head.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request (operation, push_value, source_slot,
//   target_slot); out_rsp returns one response per request with status,
//   entry_count, head_value and tail_value as they stand after the request.
//   Timing: the request is registered together with a read of the source
//   slot, the cells update in the next cycle, and the tail is then read
//   into the output register once that register is free. in_req.ready is
//   high only in the idle state, so no new request is taken until the last
//   one has gone through its three steps (slot read, cell update, tail read).
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   response; slot contents are not cleared and are never read unwritten.
//   Stall: a response waits in the output register while out_rsp.ready is
//   low. The next request is still accepted and worked up to its tail read,
//   then holds until the output register frees.
// ----------------------------------------------------------------------------
module queue_with_move_forward_unit import qmf_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qmf_req_if.sink   in_req,
  qmf_rsp_if.source out_rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_APPLY = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic [SLOT_W-1:0]     src_r;
  logic [SLOT_W-1:0]     dst_r;
  logic [DATA_WIDTH-1:0] push_r;
  logic [DATA_WIDTH-1:0] held_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  status_t               status_r, status_nxt;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] sel_held;
  logic [DATA_WIDTH-1:0] tail_rd;
  logic [CNT_W-1:0]      tail_idx;
  logic                  acc;
  logic                  apply;
  logic                  load_out;
  logic                  full;
  logic                  empty;
  logic                  src_bad;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_count_r;
  logic [DATA_WIDTH-1:0] out_head_r;
  logic [DATA_WIDTH-1:0] out_tail_r;

  assign in_req.ready = (state_r == S_IDLE);
  assign acc          = in_req.valid && in_req.ready;
  assign apply        = (state_r == S_APPLY);
  assign load_out     = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  // ---- cell row ------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v;
    logic [DATA_WIDTH-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    qmf_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .src_slot    (src_r),
      .dst_slot    (dst_r),
      .wr_slot     (count_r),
      .push_value  (push_r),
      .held_value  (held_r),
      .head_value  (cell_q[0]),
      .left_value  (left_v),
      .right_value (right_v),
      .slot_q      (cell_q[i])
    );
  end

  // ---- slot reads: one-hot AND-OR over the row -----------------------------
  assign tail_idx = count_r - 1'b1;

  always_comb begin
    sel_held = '0;
    tail_rd  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) == CW'(in_req.source_slot)) begin
        sel_held = sel_held | cell_q[i];
      end
      if (CNT_W'(i) == tail_idx) begin
        tail_rd = tail_rd | cell_q[i];
      end
    end
  end

  // ---- request decode ------------------------------------------------------
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign src_bad = (CW'(src_r) >= CW'(count_r));

  always_comb begin
    ctrl       = '0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    unique case (op_r)
      OP_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.push_en = apply;
          count_nxt    = count_r + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.pop_en = apply;
          count_nxt   = count_r - 1'b1;
        end
      end
      OP_MOVE: begin
        if (src_bad || dst_r > src_r) begin
          status_nxt = ST_BAD_SLOT;
        end else begin
          ctrl.move_en = apply;
        end
      end
      OP_SWAP: begin
        if (src_bad) begin
          status_nxt = ST_BAD_SLOT;
        end else begin
          ctrl.swap_en = apply;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // ---- sequencing ----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply) begin
        count_r <= count_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r   <= in_req.operation;
      src_r  <= in_req.source_slot;
      dst_r  <= in_req.target_slot;
      push_r <= in_req.push_value;
      held_r <= sel_held;
    end
    if (apply) begin
      status_r <= status_nxt;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_head_r   <= empty ? '0 : cell_q[0];
      out_tail_r   <= empty ? '0 : tail_rd;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = out_count_r;
  assign out_rsp.head_value  = out_head_r;
  assign out_rsp.tail_value  = out_tail_r;

  // ---- checks --------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |=> (count_r == $past(count_r) ||
                            count_r == $past(count_r) + 1'b1 ||
                            count_r == $past(count_r) - 1'b1))
    else $error("entry count moved by more than one");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_APPLY |=> count_r == $past(count_r))
    else $error("entry count changed outside update cycle");

  a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("response raised without a finished item");

  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_count_r == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_empty_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_EMPTY |-> out_count_r == '0)
    else $error("empty status with entries held");

endmodule

// ----- design/qmf_cell.sv -----
// ----------------------------------------------------------------------------
// qmf_cell: one queue slot
// Holds one word and picks its next value from its neighbors or the
// broadcast data, deciding locally from its own index.
// ----------------------------------------------------------------------------
module qmf_cell import qmf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = 8,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [SLOT_W-1:0]     src_slot,
  input  logic [SLOT_W-1:0]     dst_slot,
  input  logic [CNT_W-1:0]      wr_slot,
  input  logic [DATA_WIDTH-1:0] push_value,
  input  logic [DATA_WIDTH-1:0] held_value,
  input  logic [DATA_WIDTH-1:0] head_value,
  input  logic [DATA_WIDTH-1:0] left_value,
  input  logic [DATA_WIDTH-1:0] right_value,
  output logic [DATA_WIDTH-1:0] slot_q
);

  localparam int CW = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  logic [CW-1:0]         idx;
  logic [CW-1:0]         src;
  logic [CW-1:0]         dst;
  logic [CW-1:0]         wr;
  logic [DATA_WIDTH-1:0] slot_r;
  logic [DATA_WIDTH-1:0] slot_nxt;

  assign idx = CW'(INDEX);
  assign src = CW'(src_slot);
  assign dst = CW'(dst_slot);
  assign wr  = CW'(wr_slot);

  always_comb begin
    slot_nxt = slot_r;
    priority if (ctrl.push_en && idx == wr) begin
      slot_nxt = push_value;
    end else if (ctrl.pop_en) begin
      // slots past the tail shift too; they are never read before a push
      slot_nxt = right_value;
    end else if (ctrl.move_en && idx == dst) begin
      slot_nxt = held_value;
    end else if (ctrl.move_en && idx > dst && idx <= src) begin
      slot_nxt = left_value;
    end else if (ctrl.swap_en && idx == '0) begin
      slot_nxt = held_value;
    end else if (ctrl.swap_en && idx == src) begin
      slot_nxt = head_value;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q = slot_r;

endmodule
